[rtl/core/hwj_pkg.sv]
`timescale 1ns / 1ps

package hwj_pkg;

  // fixed field widths
  localparam int BTN_PINS  = 12;
  localparam int BTN_IDX_W = 4;
  localparam int STEP_W    = 24;
  localparam int COUNT_W   = 32;

  // default parameter values
  localparam int NUM_BUTTONS_DEF = 12;
  localparam int POS_WIDTH_DEF   = 32;

  // input command codes
  localparam logic [2:0] CMD_ENC  = 3'd0;
  localparam logic [2:0] CMD_AXIS = 3'd1;
  localparam logic [2:0] CMD_FEED = 3'd2;
  localparam logic [2:0] CMD_EMS  = 3'd3;
  localparam logic [2:0] CMD_BTN  = 3'd4;

  // configuration register indexes
  localparam logic [1:0] REG_STEP_FULL  = 2'd0;
  localparam logic [1:0] REG_STEP_MILLI = 2'd1;
  localparam logic [1:0] REG_STEP_MICRO = 2'd2;
  localparam logic [1:0] REG_STEP_NANO  = 2'd3;

  localparam logic [STEP_W-1:0] STEP_FULL_RST  = 24'd1000;
  localparam logic [STEP_W-1:0] STEP_MILLI_RST = 24'd100;
  localparam logic [STEP_W-1:0] STEP_MICRO_RST = 24'd10;
  localparam logic [STEP_W-1:0] STEP_NANO_RST  = 24'd1;

  // axis and feed selections
  localparam logic [1:0] AXIS_X = 2'd0;
  localparam logic [1:0] AXIS_Y = 2'd1;
  localparam logic [1:0] AXIS_Z = 2'd2;
  localparam logic [1:0] FEED_FULL  = 2'd0;
  localparam logic [1:0] FEED_MILLI = 2'd1;
  localparam logic [1:0] FEED_MICRO = 2'd2;
  localparam logic [1:0] FEED_NANO  = 2'd3;

  // result kinds
  localparam logic [2:0] KIND_JOG      = 3'd0;
  localparam logic [2:0] KIND_SENT     = 3'd1;
  localparam logic [2:0] KIND_BLOCKED  = 3'd2;
  localparam logic [2:0] KIND_ENGAGED  = 3'd3;
  localparam logic [2:0] KIND_RELEASED = 3'd4;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_LOAD,
    OP_ENC,
    OP_AXIS,
    OP_FEED,
    OP_EMS,
    OP_JOG,
    OP_BTN
  } op_t;

  typedef struct packed {
    op_t                  op;
    logic [BTN_IDX_W-1:0] btn_idx;
  } hwj_cmd_t;

  typedef struct packed {
    logic [2:0] cmd;
    logic       ems_change;
    logic       detent;
    logic       out_free;
    logic       btn_pressed;
  } hwj_status_t;

  // quadrature transition step, index is {previous pair, new pair}
  function automatic logic signed [1:0] quad_step(input logic [3:0] idx);
    logic signed [1:0] s;
    case (idx)
      4'd1, 4'd7, 4'd8, 4'd14: s = -2'sd1;
      4'd2, 4'd4, 4'd11, 4'd13: s = 2'sd1;
      default: s = 2'sd0;
    endcase
    return s;
  endfunction

endpackage

[rtl/core/hwj_ctrl.sv]
`timescale 1ns / 1ps

module hwj_ctrl #(
  parameter int NUM_BUTTONS = hwj_pkg::NUM_BUTTONS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                s_tvalid,
  output logic                s_tready,
  input  hwj_pkg::hwj_status_t status,
  output hwj_pkg::hwj_cmd_t    cmd
);
  import hwj_pkg::*;

  localparam int BTN_SCAN = (NUM_BUTTONS < BTN_PINS) ? NUM_BUTTONS : BTN_PINS;
  localparam logic [BTN_IDX_W-1:0] BTN_LAST = BTN_IDX_W'(BTN_SCAN - 1);

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_JOG,
    S_SCAN
  } state_t;

  state_t               state, state_next;
  logic [BTN_IDX_W-1:0] btn_idx, btn_idx_next;
  op_t                  op;

  assign s_tready    = (state == S_IDLE);
  assign cmd.op      = op;
  assign cmd.btn_idx = btn_idx;

  always_comb begin
    state_next   = state;
    btn_idx_next = btn_idx;
    op           = OP_NONE;
    case (state)
      S_IDLE: begin
        if (s_tvalid) begin
          op         = OP_LOAD;
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        case (status.cmd)
          CMD_ENC: begin
            op         = OP_ENC;
            state_next = S_JOG;
          end
          CMD_AXIS: begin
            op         = OP_AXIS;
            state_next = S_IDLE;
          end
          CMD_FEED: begin
            op         = OP_FEED;
            state_next = S_IDLE;
          end
          CMD_EMS: begin
            if (!status.ems_change) begin
              state_next = S_IDLE;
            end else if (status.out_free) begin
              op         = OP_EMS;
              state_next = S_IDLE;
            end
          end
          CMD_BTN: begin
            btn_idx_next = '0;
            state_next   = S_SCAN;
          end
          default: state_next = S_IDLE;
        endcase
      end
      S_JOG: begin
        if (!status.detent) begin
          state_next = S_IDLE;
        end else if (status.out_free) begin
          op         = OP_JOG;
          state_next = S_IDLE;
        end
      end
      S_SCAN: begin
        // one button per cycle, held while a report waits for the output
        if (!status.btn_pressed || status.out_free) begin
          if (status.btn_pressed) begin
            op = OP_BTN;
          end
          if (btn_idx == BTN_LAST) begin
            state_next = S_IDLE;
          end else begin
            btn_idx_next = btn_idx + 1'b1;
          end
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      btn_idx <= '0;
    end else begin
      state   <= state_next;
      btn_idx <= btn_idx_next;
    end
  end

endmodule

[rtl/core/hwj_dp.sv]
`timescale 1ns / 1ps

module hwj_dp #(
  parameter int NUM_BUTTONS = hwj_pkg::NUM_BUTTONS_DEF,
  parameter int POS_WIDTH   = hwj_pkg::POS_WIDTH_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  hwj_pkg::hwj_cmd_t    cmd,
  output hwj_pkg::hwj_status_t status,
  input  logic                cfg_valid,
  input  logic [1:0]          cfg_index,
  input  logic [23:0]         cfg_data,
  input  logic [23:0]         s_tdata,
  input  logic [2:0]          s_tuser,
  output logic                m_tvalid,
  input  logic                m_tready,
  output logic [103:0]        m_tdata,
  output logic [2:0]          m_tuser,
  output logic                m_tlast
);
  import hwj_pkg::*;

  localparam int BTN_SCAN = (NUM_BUTTONS < BTN_PINS) ? NUM_BUTTONS : BTN_PINS;
  localparam int SUM_W    = ((POS_WIDTH > STEP_W + 1) ? POS_WIDTH : STEP_W + 1) + 1;
  localparam logic signed [SUM_W-1:0] POS_MAX = SUM_W'((64'sd1 <<< (POS_WIDTH - 1)) - 64'sd1);
  localparam logic signed [SUM_W-1:0] POS_MIN = -POS_MAX - SUM_W'(1);

  // step registers
  logic [STEP_W-1:0] step_full, step_milli, step_micro, step_nano;

  // captured item
  logic [2:0]          in_cmd;
  logic [1:0]          in_ab;
  logic [2:0]          in_axis_low;
  logic [2:0]          in_feed_low;
  logic                in_ems;
  logic [BTN_SCAN-1:0] in_pressed;

  // block state
  logic [1:0]               prev_ab;
  logic signed [3:0]        detent_acc;
  logic [COUNT_W-1:0]       wheel_detents;
  logic signed [POS_WIDTH-1:0] position [3];
  logic [1:0]               sel_axis;
  logic [1:0]               sel_feed;
  logic signed [1:0]        direction;
  logic                     emergency;
  logic [BTN_SCAN-1:0]      toggle_bits;
  logic                     detent;

  // result register
  logic [2:0]          out_kind;
  logic [1:0]          out_axis;
  logic [1:0]          out_dir;
  logic [STEP_W-1:0]   out_size;
  logic [31:0]         out_pos;
  logic [COUNT_W-1:0]  out_count;
  logic [BTN_IDX_W-1:0] out_idx;
  logic                out_off;
  logic                out_last;

  logic                     out_free;
  logic                     out_load;
  logic signed [3:0]        acc_sum;
  logic [STEP_W-1:0]        feed_step;
  logic signed [POS_WIDTH-1:0] pos_cur;
  logic signed [SUM_W-1:0]  delta;
  logic signed [SUM_W-1:0]  pos_sum;
  logic signed [POS_WIDTH-1:0] pos_sat;
  logic [BTN_SCAN-1:0]      btn_sel;
  logic                     btn_rest;

  assign out_free = !m_tvalid || m_tready;
  assign out_load = (cmd.op == OP_JOG) || (cmd.op == OP_EMS) || (cmd.op == OP_BTN);

  assign acc_sum = detent_acc + 4'(quad_step({prev_ab, in_ab}));

  always_comb begin
    case (sel_feed)
      FEED_FULL:  feed_step = step_full;
      FEED_MILLI: feed_step = step_milli;
      FEED_MICRO: feed_step = step_micro;
      default:    feed_step = step_nano;
    endcase
  end

  // add the signed step and clamp to the position range
  always_comb begin
    pos_cur = position[AXIS_X];
    case (sel_axis)
      AXIS_Y:  pos_cur = position[AXIS_Y];
      AXIS_Z:  pos_cur = position[AXIS_Z];
      default: pos_cur = position[AXIS_X];
    endcase
    delta = SUM_W'($signed({1'b0, feed_step}));
    if (direction < 0) begin
      delta = -delta;
    end
    pos_sum = SUM_W'(pos_cur) + delta;
    if (pos_sum > POS_MAX) begin
      pos_sat = POS_WIDTH'(POS_MAX);
    end else if (pos_sum < POS_MIN) begin
      pos_sat = POS_WIDTH'(POS_MIN);
    end else begin
      pos_sat = POS_WIDTH'(pos_sum);
    end
  end

  always_comb begin
    btn_rest = 1'b0;
    for (int i = 0; i < BTN_SCAN; i++) begin
      btn_sel[i] = (BTN_IDX_W'(i) == cmd.btn_idx);
      btn_rest   = btn_rest | (in_pressed[i] & (BTN_IDX_W'(i) > cmd.btn_idx));
    end
  end

  assign status.cmd         = in_cmd;
  assign status.ems_change  = (in_ems != emergency);
  assign status.detent      = detent;
  assign status.out_free    = out_free;
  assign status.btn_pressed = |(in_pressed & btn_sel);

  always_ff @(posedge clk) begin
    if (rst) begin
      step_full     <= STEP_FULL_RST;
      step_milli    <= STEP_MILLI_RST;
      step_micro    <= STEP_MICRO_RST;
      step_nano     <= STEP_NANO_RST;
      prev_ab       <= '0;
      detent_acc    <= '0;
      wheel_detents <= '0;
      position[AXIS_X] <= '0;
      position[AXIS_Y] <= '0;
      position[AXIS_Z] <= '0;
      sel_axis      <= AXIS_X;
      sel_feed      <= FEED_NANO;
      direction     <= '0;
      emergency     <= 1'b0;
      toggle_bits   <= '0;
      detent        <= 1'b0;
      m_tvalid      <= 1'b0;
    end else begin
      if (cfg_valid) begin
        case (cfg_index)
          REG_STEP_FULL:  step_full  <= cfg_data;
          REG_STEP_MILLI: step_milli <= cfg_data;
          REG_STEP_MICRO: step_micro <= cfg_data;
          REG_STEP_NANO:  step_nano  <= cfg_data;
          default: ;
        endcase
      end
      case (cmd.op)
        OP_ENC: begin
          detent <= 1'b0;
          if (!emergency && (in_ab != prev_ab)) begin
            prev_ab <= in_ab;
            if ((acc_sum == 4'sd4) || (acc_sum == -4'sd4)) begin
              detent     <= 1'b1;
              detent_acc <= '0;
              direction  <= (acc_sum > 0) ? 2'sd1 : -2'sd1;
            end else begin
              detent_acc <= acc_sum;
            end
          end
        end
        OP_AXIS: begin
          if (!in_axis_low[1]) begin
            sel_axis <= AXIS_Y;
          end else if (!in_axis_low[2]) begin
            sel_axis <= AXIS_Z;
          end else if (!in_axis_low[0]) begin
            sel_axis <= AXIS_X;
          end
          direction <= '0;
        end
        OP_FEED: begin
          if (!in_feed_low[0]) begin
            sel_feed <= FEED_FULL;
          end else if (!in_feed_low[1]) begin
            sel_feed <= FEED_MILLI;
          end else if (!in_feed_low[2]) begin
            sel_feed <= FEED_MICRO;
          end else begin
            sel_feed <= FEED_NANO;
          end
        end
        OP_EMS: emergency <= in_ems;
        OP_JOG: begin
          detent <= 1'b0;
          wheel_detents <= (direction > 0) ? wheel_detents + 1'b1 : wheel_detents - 1'b1;
          case (sel_axis)
            AXIS_Y:  position[AXIS_Y] <= pos_sat;
            AXIS_Z:  position[AXIS_Z] <= pos_sat;
            default: position[AXIS_X] <= pos_sat;
          endcase
        end
        OP_BTN: begin
          if (!emergency) begin
            toggle_bits <= toggle_bits ^ btn_sel;
          end
        end
        default: ;
      endcase
      if (out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // item capture and result payload
  always_ff @(posedge clk) begin
    if (cmd.op == OP_LOAD) begin
      in_cmd      <= s_tuser;
      in_ab       <= {s_tdata[0], s_tdata[1]};
      in_axis_low <= s_tdata[4:2];
      in_feed_low <= s_tdata[7:5];
      in_ems      <= s_tdata[8];
      in_pressed  <= ~s_tdata[9 +: BTN_SCAN];
    end
    if (out_load) begin
      out_axis  <= '0;
      out_dir   <= '0;
      out_size  <= '0;
      out_pos   <= '0;
      out_count <= '0;
      out_idx   <= '0;
      out_off   <= 1'b0;
      out_last  <= 1'b1;
      case (cmd.op)
        OP_JOG: begin
          out_kind  <= KIND_JOG;
          out_axis  <= sel_axis;
          out_dir   <= direction;
          out_size  <= feed_step;
          out_pos   <= 32'(pos_sat);
          out_count <= (direction > 0) ? wheel_detents + 1'b1 : wheel_detents - 1'b1;
        end
        OP_EMS: out_kind <= in_ems ? KIND_ENGAGED : KIND_RELEASED;
        default: begin
          out_kind <= emergency ? KIND_BLOCKED : KIND_SENT;
          out_idx  <= cmd.btn_idx;
          out_off  <= |(toggle_bits & btn_sel);
          out_last <= !btn_rest;
        end
      endcase
    end
  end

  assign m_tdata = {7'd0, out_off, out_idx, out_count, out_pos, out_size, out_dir, out_axis};
  assign m_tuser = out_kind;
  assign m_tlast = out_last;

endmodule

[rtl/core/handwheel_jog_controller.sv]
`timescale 1ns / 1ps
// channel  | signals                                  | carries
// s        | s_tvalid s_tready s_tdata s_tuser        | pin samples and events
// m        | m_tvalid m_tready m_tdata m_tuser m_tlast | jog, button and emergency reports
// cfg      | cfg_valid cfg_ready cfg_index cfg_data   | step size register writes
//
// items pass load and execute; encoder samples then jog, and button samples then scan
// min(NUM_BUTTONS, 12) buttons, one a cycle unless stalled. rst is synchronous and
// clears all state at once but the captured item and result payload; steps return to
// their defaults. a result waits in the output register while m_tready is low; a new
// item is still taken, and the block stalls only when it has a further result to place.

module handwheel_jog_controller #(
  parameter int NUM_BUTTONS = hwj_pkg::NUM_BUTTONS_DEF,
  parameter int POS_WIDTH   = hwj_pkg::POS_WIDTH_DEF
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  // enc_a, enc_b, axis_x_low, axis_y_low, axis_z_low, feed_full_low,
  // feed_milli_low, feed_micro_low, ems_level, buttons_low[11:0], zero fill
  input  logic [23:0]  s_tdata,
  // command
  input  logic [2:0]   s_tuser,
  output logic         m_tvalid,
  input  logic         m_tready,
  // axis, step_dir, step_size, axis_position, wheel_count, button_index,
  // off_phase, zero fill
  output logic [103:0] m_tdata,
  // kind
  output logic [2:0]   m_tuser,
  output logic         m_tlast,
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [1:0]   cfg_index,
  input  logic [23:0]  cfg_data
);
  import hwj_pkg::*;

  localparam int BTN_SCAN = (NUM_BUTTONS < BTN_PINS) ? NUM_BUTTONS : BTN_PINS;

  hwj_cmd_t    cmd;
  hwj_status_t status;

  assign cfg_ready = 1'b1;

  hwj_ctrl #(
    .NUM_BUTTONS (NUM_BUTTONS)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .status   (status),
    .cmd      (cmd)
  );

  hwj_dp #(
    .NUM_BUTTONS (NUM_BUTTONS),
    .POS_WIDTH   (POS_WIDTH)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .status    (status),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .m_tlast   (m_tlast)
  );

  // an accepted item keeps the block busy in the next cycle
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("input taken on consecutive cycles");

  // a jog report always carries a direction of plus or minus one
  a_jog_dir: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tuser == KIND_JOG) |-> (m_tdata[3:2] == 2'b01) || (m_tdata[3:2] == 2'b11))
    else $error("jog report without direction");

  // button reports stay within the scanned buttons
  a_btn_idx: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && ((m_tuser == KIND_SENT) || (m_tuser == KIND_BLOCKED))
    |-> (m_tdata[95:92] < BTN_IDX_W'(BTN_SCAN)))
    else $error("button index out of range");

endmodule

[tb/tb_top.sv]
`timescale 1ns / 1ps

module tb_top;
  import hwj_pkg::*;

  localparam logic [1:0] DIR_NONE = 2'b00;
  localparam logic [1:0] DIR_UP   = 2'b01;
  localparam logic [1:0] DIR_DOWN = 2'b11;
  localparam logic [2:0] CMD_SPARE_LO = 3'd5;
  localparam logic [2:0] CMD_SPARE_HI = 3'd7;
  localparam logic [STEP_W-1:0] STEP_MAX = '1;
  localparam longint POS_MAX = 64'sh7FFF_FFFF;
  localparam longint POS_MIN = -POS_MAX - 1;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int SETTLE_CYCLES  = 30;
  localparam int HOLD_CYCLES    = 400;

  // pin sample as it sits in s_tdata, last member in bit 0
  typedef struct packed {
    logic [2:0]  fill;
    logic [11:0] buttons_low;
    logic        ems_level;
    logic        feed_micro_low;
    logic        feed_milli_low;
    logic        feed_full_low;
    logic        axis_z_low;
    logic        axis_y_low;
    logic        axis_x_low;
    logic        enc_b;
    logic        enc_a;
  } pins_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [1:0]  axis;
    logic [1:0]  dir;
    logic [23:0] size;
    logic [31:0] position;
    logic [31:0] count;
    logic [3:0]  btn_idx;
    logic        off;
    logic        last;
  } report_t;

  logic         clk;
  logic         rst;
  logic         s_tvalid;
  logic         s_tready;
  logic [23:0]  s_tdata;
  logic [2:0]   s_tuser;
  logic         m_tvalid;
  logic         m_tready;
  logic [103:0] m_tdata;
  logic [2:0]   m_tuser;
  logic         m_tlast;
  logic         cfg_valid;
  logic         cfg_ready;
  logic [1:0]   cfg_index;
  logic [23:0]  cfg_data;

  handwheel_jog_controller uut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .m_tlast   (m_tlast),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // pendant state as predicted
  logic [1:0]        last_pair;
  int                detent_acc;
  logic [31:0]       wheel_count;
  logic signed [31:0] axis_pos [3];
  logic [1:0]        sel_axis;
  logic [1:0]        sel_feed;
  logic [1:0]        jog_dir;
  logic              ems_latched;
  logic [11:0]       toggles;
  logic [23:0]       step_of [4];

  report_t report_q [$];
  report_t got_report;
  int      fails;

  // stimulus side
  logic [1:0] wheel_phase;
  int         wheel_dir;
  bit         no_gaps;
  int         hold_left;

  // position of a pair along the quadrature cycle 00, 10, 11, 01
  function automatic logic [1:0] gray_pos(input logic [1:0] ab);
    return {ab[0], ab[1] ^ ab[0]};
  endfunction

  task automatic reset_pendant();
    last_pair   = 2'b00;
    detent_acc  = 0;
    wheel_count = '0;
    for (int i = 0; i < 3; i++) axis_pos[i] = '0;
    sel_axis    = AXIS_X;
    sel_feed    = FEED_NANO;
    jog_dir     = DIR_NONE;
    ems_latched = 1'b0;
    toggles     = '0;
    step_of[REG_STEP_FULL]  = STEP_FULL_RST;
    step_of[REG_STEP_MILLI] = STEP_MILLI_RST;
    step_of[REG_STEP_MICRO] = STEP_MICRO_RST;
    step_of[REG_STEP_NANO]  = STEP_NANO_RST;
  endtask

  task automatic predict_reports(input logic [2:0] cmd, input pins_t p);
    logic [1:0]  pair;
    logic [1:0]  turn;
    logic [1:0]  ax;
    logic [23:0] size;
    longint      moved;
    report_t     r;
    int          n;
    n = 0;
    r = '0;
    case (cmd)
      CMD_ENC: begin
        pair = {p.enc_a, p.enc_b};
        if (!ems_latched && pair != last_pair) begin
          // both channels changing gives a half turn, which counts as nothing
          turn = gray_pos(pair) - gray_pos(last_pair);
          last_pair = pair;
          if (turn == 2'd1) detent_acc = detent_acc + 1;
          else if (turn == 2'd3) detent_acc = detent_acc - 1;
          if (detent_acc == 4 || detent_acc == -4) begin
            jog_dir = (detent_acc > 0) ? DIR_UP : DIR_DOWN;
            detent_acc = 0;
            ax = (sel_axis > AXIS_Z) ? AXIS_X : sel_axis;
            size = step_of[sel_feed];
            wheel_count = wheel_count + ((jog_dir == DIR_UP) ? 32'd1 : 32'hFFFF_FFFF);
            moved = axis_pos[ax];
            if (jog_dir == DIR_UP) moved = moved + size;
            else moved = moved - size;
            if (moved > POS_MAX) moved = POS_MAX;
            if (moved < POS_MIN) moved = POS_MIN;
            axis_pos[ax] = moved[31:0];
            r.kind     = KIND_JOG;
            r.axis     = ax;
            r.dir      = jog_dir;
            r.size     = size;
            r.position = axis_pos[ax];
            r.count    = wheel_count;
            r.last     = 1'b1;
            report_q.push_back(r);
          end
        end
      end
      CMD_AXIS: begin
        if (!p.axis_x_low) sel_axis = AXIS_X;
        if (!p.axis_y_low) sel_axis = AXIS_Y;
        else if (!p.axis_z_low) sel_axis = AXIS_Z;
        jog_dir = DIR_NONE;
      end
      CMD_FEED: begin
        if (!p.feed_full_low) sel_feed = FEED_FULL;
        else if (!p.feed_milli_low) sel_feed = FEED_MILLI;
        else if (!p.feed_micro_low) sel_feed = FEED_MICRO;
        else sel_feed = FEED_NANO;
      end
      CMD_EMS: begin
        if (p.ems_level != ems_latched) begin
          ems_latched = p.ems_level;
          r.kind = ems_latched ? KIND_ENGAGED : KIND_RELEASED;
          r.last = 1'b1;
          report_q.push_back(r);
        end
      end
      CMD_BTN: begin
        for (int i = 0; i < BTN_PINS; i++) begin
          if (!p.buttons_low[i]) begin
            r = '0;
            r.kind    = ems_latched ? KIND_BLOCKED : KIND_SENT;
            r.btn_idx = i[3:0];
            r.off     = toggles[i];
            if (!ems_latched) toggles[i] = ~toggles[i];
            report_q.push_back(r);
            n++;
          end
        end
        if (n > 0) report_q[report_q.size() - 1].last = 1'b1;
      end
      default: ;
    endcase
  endtask

  function automatic int pick_gap();
    int r;
    if (no_gaps) return 0;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic pins_t random_pins();
    pins_t p;
    p = pins_t'(24'($urandom));
    p.fill = '0;
    return p;
  endfunction

  function automatic logic coin();
    return 1'($urandom_range(0, 1));
  endfunction

  task automatic send_item(input logic [2:0] cmd, input pins_t p);
    int gap;
    gap = pick_gap();
    @(negedge clk);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= cmd;
    s_tdata  <= p;
    do @(posedge clk); while (!s_tready);
    predict_reports(cmd, p);
  endtask

  task automatic send_pair(input logic a, input logic b);
    pins_t p;
    p = random_pins();
    p.enc_a = a;
    p.enc_b = b;
    wheel_phase = gray_pos({a, b});
    send_item(CMD_ENC, p);
  endtask

  // quarter steps along the quadrature cycle, dir +1 or -1
  task automatic turn_wheel(input int quarters, input int dir);
    logic [1:0] ph;
    for (int i = 0; i < quarters; i++) begin
      ph = wheel_phase + ((dir > 0) ? 2'd1 : 2'd3);
      send_pair(ph[1] ^ ph[0], ph[1]);
    end
  endtask

  task automatic send_axis(input logic x_low, input logic y_low, input logic z_low);
    pins_t p;
    p = random_pins();
    p.axis_x_low = x_low;
    p.axis_y_low = y_low;
    p.axis_z_low = z_low;
    send_item(CMD_AXIS, p);
  endtask

  task automatic send_feed(input logic full_low, input logic milli_low,
                           input logic micro_low);
    pins_t p;
    p = random_pins();
    p.feed_full_low  = full_low;
    p.feed_milli_low = milli_low;
    p.feed_micro_low = micro_low;
    send_item(CMD_FEED, p);
  endtask

  task automatic send_ems(input logic lvl);
    pins_t p;
    p = random_pins();
    p.ems_level = lvl;
    send_item(CMD_EMS, p);
  endtask

  task automatic send_buttons(input logic [11:0] levels);
    pins_t p;
    p = random_pins();
    p.buttons_low = levels;
    send_item(CMD_BTN, p);
  endtask

  task automatic write_step(input logic [1:0] idx, input logic [23:0] value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    step_of[idx] = value;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // drain every expected report, then let a silent button scan run out
  task automatic wait_idle();
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (report_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic random_items(input int count);
    int          i;
    int          r;
    int          k;
    logic        lvl;
    logic [11:0] levels;
    i = 0;
    while (i < count) begin
      if ($urandom_range(0, 49) == 0) no_gaps = ~no_gaps;
      r = $urandom_range(0, 99);
      if (r < 55) begin
        if ($urandom_range(0, 9) < 3) wheel_dir = -wheel_dir;
        k = $urandom_range(1, 12);
        turn_wheel(k, wheel_dir);
        i += k;
      end else begin
        if (r < 60) send_pair(coin(), coin());
        else if (r < 68)
          send_axis(coin(), coin(), coin());
        else if (r < 76)
          send_feed(coin(), coin(), coin());
        else if (r < 82) begin
          // leave emergency again soon so the wheel keeps moving
          if (ems_latched) lvl = ($urandom_range(0, 3) == 0);
          else lvl = ($urandom_range(0, 2) == 0);
          send_ems(lvl);
        end else if (r < 97) begin
          levels = '1;
          for (int b = 0; b < BTN_PINS; b++)
            if ($urandom_range(0, 3) == 0) levels[b] = 1'b0;
          if ($urandom_range(0, 9) == 0) levels = coin() ? '0 : '1;
          send_buttons(levels);
        end else begin
          send_item(3'($urandom_range(CMD_SPARE_LO, CMD_SPARE_HI)), random_pins());
        end
        i++;
      end
    end
    no_gaps = 1'b0;
  endtask

  task automatic test_reset_defaults();
    // one detent each way on X with the finest feed
    turn_wheel(4, 1);
    turn_wheel(4, -1);
  endtask

  task automatic test_directed();
    wait_idle();
    write_step(REG_STEP_FULL, STEP_MAX);
    write_step(REG_STEP_MILLI, '0);
    write_step(REG_STEP_MICRO, 24'($urandom));
    write_step(REG_STEP_NANO, STEP_NANO_RST);
    send_feed(1'b0, 1'b0, 1'b1);
    send_axis(1'b0, 1'b0, 1'b1);
    turn_wheel(4, -1);
    send_axis(1'b0, 1'b1, 1'b0);
    turn_wheel(4, 1);
    send_axis(1'b1, 1'b1, 1'b1);
    send_feed(1'b1, 1'b0, 1'b0);
    turn_wheel(4, 1);
    send_feed(1'b1, 1'b1, 1'b0);
    send_feed(1'b1, 1'b1, 1'b1);
    // repeated pair, then a jump across the cycle
    send_pair(wheel_phase[1] ^ wheel_phase[0], wheel_phase[1]);
    send_pair(~(wheel_phase[1] ^ wheel_phase[0]), ~wheel_phase[1]);
    send_ems(1'b1);
    send_ems(1'b1);
    turn_wheel(2, 1);
    send_buttons('0);
    send_ems(1'b0);
    send_buttons('0);
    send_buttons(12'h5A5);
    send_buttons('1);
    for (int c = CMD_SPARE_LO; c <= CMD_SPARE_HI; c++) send_item(3'(c), random_pins());
  endtask

  task automatic test_position_limits();
    wait_idle();
    write_step(REG_STEP_FULL, STEP_MAX);
    send_feed(1'b0, 1'b1, 1'b1);
    send_axis(1'b0, 1'b1, 1'b1);
    // the largest step reaches the upper bound on the 129th detent
    turn_wheel(4 * 130, 1);
    turn_wheel(8, -1);
  endtask

  task automatic test_step_settings();
    for (int s = 0; s < 5; s++) begin
      wait_idle();
      for (int idx = REG_STEP_FULL; idx <= REG_STEP_NANO; idx++) begin
        case (s)
          0: write_step(2'(idx), '0);
          1: write_step(2'(idx), STEP_MAX);
          2: write_step(2'(idx), (idx == REG_STEP_FULL) ? STEP_FULL_RST :
                                 (idx == REG_STEP_MILLI) ? STEP_MILLI_RST :
                                 (idx == REG_STEP_MICRO) ? STEP_MICRO_RST : STEP_NANO_RST);
          default: write_step(2'(idx), 24'($urandom));
        endcase
      end
      random_items(10);
    end
  endtask

  task automatic test_backpressure();
    wait_idle();
    hold_left = HOLD_CYCLES;
    for (int i = 0; i < 4; i++) begin
      send_buttons('0);
      turn_wheel(4, wheel_dir);
    end
  endtask

  task automatic test_random();
    wait_idle();
    random_items(40);
  endtask

  // sink side ready, with random stalls and one long hold on request
  initial begin : sink
    int stall_left;
    stall_left = 0;
    m_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        m_tready <= 1'b0;
        hold_left = hold_left - 1;
      end else if (stall_left > 0) begin
        m_tready <= 1'b0;
        stall_left = stall_left - 1;
      end else begin
        m_tready <= 1'b1;
        if (!no_gaps && $urandom_range(0, 3) == 0) stall_left = pick_gap();
      end
    end
  end

  function automatic void check_field(input string name, input logic [31:0] want_v,
                                      input logic [31:0] got_v);
    if (want_v !== got_v) begin
      $error("%s mismatch: expected %0h, got %0h", name, want_v, got_v);
      fails++;
    end
  endfunction

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      if (report_q.size() == 0) begin
        $error("report with nothing expected: kind %0d", m_tuser);
        fails++;
      end else begin
        got_report = report_q.pop_front();
        check_field("kind", got_report.kind, m_tuser);
        check_field("axis", got_report.axis, m_tdata[1:0]);
        check_field("step_dir", got_report.dir, m_tdata[3:2]);
        check_field("step_size", got_report.size, m_tdata[27:4]);
        check_field("axis_position", got_report.position, m_tdata[59:28]);
        check_field("wheel_count", got_report.count, m_tdata[91:60]);
        check_field("button_index", got_report.btn_idx, m_tdata[95:92]);
        check_field("off_phase", got_report.off, m_tdata[96]);
        check_field("last", got_report.last, m_tlast);
      end
    end
  end

  // ends the run once no transfer of any kind has happened for too long
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("tb_top: FAIL");
    $finish;
  end

  initial begin
    rst         = 1'b1;
    s_tvalid    = 1'b0;
    s_tdata     = '0;
    s_tuser     = CMD_ENC;
    cfg_valid   = 1'b0;
    cfg_index   = REG_STEP_FULL;
    cfg_data    = '0;
    fails       = 0;
    wheel_phase = 2'b00;
    wheel_dir   = 1;
    no_gaps     = 1'b0;
    hold_left   = 0;
    reset_pendant();
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_reset_defaults();
    test_directed();
    test_position_limits();
    test_step_settings();
    test_backpressure();
    test_random();
    wait_idle();
    if (fails == 0) $display("tb_top: PASS");
    else $display("tb_top: FAIL");
    $finish;
  end

endmodule
